FILE: hdl/assert_macros.svh
// Assertion macros shared by the limiter RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted (active low).
`define TWRL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("twrl assertion failed");
// Clocked check that also holds during reset.
`define TWRL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("twrl assertion failed");
`else
`define TWRL_ASSERT(lbl, clk, rst_n, prop)
`define TWRL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hdl/twrl_pkg.sv
// Shared types and constants of the two-window rate limiter.
// Depends on nothing; used by every module of the block.
package twrl_pkg;

    localparam int LOG_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF = 32;

    localparam int LIMIT_W  = 4;
    localparam int WINDOW_W = 32;
    localparam int NOW_W    = 32;
    localparam int USED_W   = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [LIMIT_W-1:0]  SHORT_LIMIT_RST  = 4'd1;
    localparam logic [LIMIT_W-1:0]  LONG_LIMIT_RST   = 4'd4;
    localparam logic [WINDOW_W-1:0] SHORT_WINDOW_RST = 32'd1;
    localparam logic [WINDOW_W-1:0] LONG_WINDOW_RST  = 32'd60;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_WINDOW  = 2'd3;

    // Per-log commands from the sequencer.
    typedef struct packed {
        logic push;
        logic pop;
    } t_log_ctrl;

endpackage

FILE: hdl/two_window_rate_limiter.sv
// Two-window rate limiter: after accept, the short log and then the long log
// pop each expired head entry until one survives or the log is empty.
// A new word is taken only once the last result is handed over; each head read
// goes through the registered log read port and the single shared age compare unit.
// Reset (i_rst_n low, synchronous): logs empty, registers at defaults, no result.
// Log memories are not cleared; only entries inside the fill count are read.
module two_window_rate_limiter #(
    parameter int LOG_DEPTH = twrl_pkg::LOG_DEPTH_DEF,
    parameter int TIME_BITS = twrl_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Attempt channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [twrl_pkg::NOW_W-1:0]     i_now_seconds,
    // Result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_granted,
    output logic [twrl_pkg::USED_W-1:0]    o_short_used,
    output logic [twrl_pkg::USED_W-1:0]    o_long_used,
    // Configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [twrl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [twrl_pkg::WINDOW_W-1:0]  i_cfg_data
);

`include "assert_macros.svh"

    localparam int FILL_W   = $clog2(LOG_DEPTH+1);
    localparam int LIM_CW   = (FILL_W > twrl_pkg::LIMIT_W) ? FILL_W : twrl_pkg::LIMIT_W;
    localparam int NOW_EXT  = (TIME_BITS > twrl_pkg::NOW_W) ? TIME_BITS : twrl_pkg::NOW_W;

    // Sequencer: accept in IDLE, then read/compare the head of each log until
    // an entry survives or the log runs empty, then hand the result over.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SRD,
        S_SCMP,
        S_LRD,
        S_LCMP,
        S_DONE
    } t_state;

    t_state r_state;

    // Configuration registers
    logic [twrl_pkg::LIMIT_W-1:0]  r_short_limit;
    logic [twrl_pkg::LIMIT_W-1:0]  r_long_limit;
    logic [twrl_pkg::WINDOW_W-1:0] r_short_window;
    logic [twrl_pkg::WINDOW_W-1:0] r_long_window;

    // Word in flight and output register
    logic [TIME_BITS-1:0]        r_now;
    logic                        r_grant;
    logic                        r_out_valid;
    logic                        r_out_granted;
    logic [twrl_pkg::USED_W-1:0] r_out_short;
    logic [twrl_pkg::USED_W-1:0] r_out_long;

    logic                  in_accept;
    logic [TIME_BITS-1:0]  now_t;
    logic                  grant;
    logic [FILL_W-1:0]     short_fill, long_fill;
    logic [TIME_BITS-1:0]  short_head, long_head;
    twrl_pkg::t_log_ctrl   short_ctrl, long_ctrl;
    logic [TIME_BITS-1:0]  cmp_entry;
    logic [twrl_pkg::WINDOW_W-1:0] cmp_window;
    logic                  expire;
    logic                  out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Keep the low TIME_BITS of the time stamp.
    assign now_t = TIME_BITS'(NOW_EXT'(i_now_seconds));

    // Inclusive limit tests; a full log refuses any grant.
    assign grant = (LIM_CW'(short_fill) <= LIM_CW'(r_short_limit))
                && (LIM_CW'(long_fill)  <= LIM_CW'(r_long_limit))
                && (short_fill < FILL_W'(LOG_DEPTH))
                && (long_fill  < FILL_W'(LOG_DEPTH));

    // Shared age unit: short log in S_SCMP, long log in S_LCMP.
    assign cmp_entry  = (r_state == S_LCMP) ? long_head : short_head;
    assign cmp_window = (r_state == S_LCMP) ? r_long_window : r_short_window;

    twrl_age_unit #(
        .TIME_BITS (TIME_BITS)
    ) u_age (
        .i_now    (r_now),
        .i_entry  (cmp_entry),
        .i_window (cmp_window),
        .o_expire (expire)
    );

    // Push both logs at accept on a grant; pop the head that the unit expires.
    always_comb begin
        short_ctrl.push = in_accept && grant;
        long_ctrl.push  = in_accept && grant;
        short_ctrl.pop  = (r_state == S_SCMP) && (short_fill != '0) && expire;
        long_ctrl.pop   = (r_state == S_LCMP) && (long_fill  != '0) && expire;
    end

    twrl_log #(
        .LOG_DEPTH (LOG_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_short_log (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (short_ctrl),
        .i_wdata     (now_t),
        .o_head_data (short_head),
        .o_fill      (short_fill)
    );

    twrl_log #(
        .LOG_DEPTH (LOG_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_long_log (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (long_ctrl),
        .i_wdata     (now_t),
        .o_head_data (long_head),
        .o_fill      (long_fill)
    );

    // Configuration writes; an index outside the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_limit  <= twrl_pkg::SHORT_LIMIT_RST;
            r_long_limit   <= twrl_pkg::LONG_LIMIT_RST;
            r_short_window <= twrl_pkg::SHORT_WINDOW_RST;
            r_long_window  <= twrl_pkg::LONG_WINDOW_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                twrl_pkg::CFG_SHORT_LIMIT: begin
                    r_short_limit <= i_cfg_data[twrl_pkg::LIMIT_W-1:0];
                end
                twrl_pkg::CFG_LONG_LIMIT: begin
                    r_long_limit <= i_cfg_data[twrl_pkg::LIMIT_W-1:0];
                end
                twrl_pkg::CFG_SHORT_WINDOW: begin
                    r_short_window <= i_cfg_data;
                end
                twrl_pkg::CFG_LONG_WINDOW: begin
                    r_long_window <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Output slot is free when empty or being taken this cycle.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result once it is taken, unless a new one loads below.
            if (r_out_valid && !i_out_stall && !((r_state == S_DONE) && out_free)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_now   <= now_t;
                        r_grant <= grant;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: begin
                    // Head read in flight through the registered port.
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    if ((short_fill != '0) && expire) begin
                        r_state <= S_SRD;
                    end else begin
                        r_state <= S_LRD;
                    end
                end
                S_LRD: begin
                    r_state <= S_LCMP;
                end
                S_LCMP: begin
                    if ((long_fill != '0) && expire) begin
                        r_state <= S_LRD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register can take the word.
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_granted <= r_grant;
                        r_out_short   <= twrl_pkg::USED_W'(short_fill);
                        r_out_long    <= twrl_pkg::USED_W'(long_fill);
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_granted    = r_out_granted;
    assign o_short_used = r_out_short;
    assign o_long_used  = r_out_long;

    // A granted word never overfills a log.
    `TWRL_ASSERT(a_short_bound, i_clk, i_rst_n, short_fill <= FILL_W'(LOG_DEPTH))
    `TWRL_ASSERT(a_long_bound, i_clk, i_rst_n, long_fill <= FILL_W'(LOG_DEPTH))
    // An accepted word starts the short-log expiry pass.
    `TWRL_ASSERT(a_accept_seq, i_clk, i_rst_n, in_accept |=> (r_state == S_SRD))
    // A new result is loaded only from the hand-over state.
    `TWRL_ASSERT(a_load_src, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
    // The shared unit serves one log at a time.
    `TWRL_ASSERT(a_one_pop, i_clk, i_rst_n, !(short_ctrl.pop && long_ctrl.pop))

endmodule

FILE: hdl/twrl_age_unit.sv
// Shared age test: wrapping age of one log entry against a window.
// Depends on twrl_pkg for the window width.
module twrl_age_unit #(
    parameter int TIME_BITS = twrl_pkg::TIME_BITS_DEF
) (
    input  logic [TIME_BITS-1:0]          i_now,
    input  logic [TIME_BITS-1:0]          i_entry,
    input  logic [twrl_pkg::WINDOW_W-1:0] i_window,
    output logic                          o_expire
);

    localparam int CMP_BITS = (TIME_BITS > twrl_pkg::WINDOW_W) ? TIME_BITS
                                                               : twrl_pkg::WINDOW_W;

    logic [TIME_BITS-1:0] age;

    // Age wraps modulo 2^TIME_BITS.
    assign age      = i_now - i_entry;
    assign o_expire = CMP_BITS'(age) > CMP_BITS'(i_window);

endmodule

FILE: hdl/twrl_log.sv
// Time-stamp log: circular memory with head pointer and fill count.
// Depends on twrl_pkg for the command struct.
module twrl_log #(
    parameter int LOG_DEPTH = twrl_pkg::LOG_DEPTH_DEF,
    parameter int TIME_BITS = twrl_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  twrl_pkg::t_log_ctrl           i_ctrl,
    input  logic [TIME_BITS-1:0]          i_wdata,
    output logic [TIME_BITS-1:0]          o_head_data,
    output logic [$clog2(LOG_DEPTH+1)-1:0] o_fill
);

    localparam int IDX_W  = $clog2(LOG_DEPTH);
    localparam int FILL_W = $clog2(LOG_DEPTH+1);

    logic [TIME_BITS-1:0] r_mem [LOG_DEPTH];
    logic [TIME_BITS-1:0] r_rd_data;
    logic [IDX_W-1:0]     r_head, n_head;
    logic [FILL_W-1:0]    r_fill, n_fill;
    logic [IDX_W:0]       tail_sum;
    logic [IDX_W-1:0]     tail;

    // Tail wraps once at most: head and fill both stay below the depth on a push.
    assign tail_sum = (IDX_W+1)'(r_head) + (IDX_W+1)'(r_fill);
    assign tail     = (tail_sum >= (IDX_W+1)'(LOG_DEPTH))
                    ? IDX_W'(tail_sum - (IDX_W+1)'(LOG_DEPTH))
                    : IDX_W'(tail_sum);

    always_comb begin
        n_head = r_head;
        n_fill = r_fill;
        if (i_ctrl.push && (r_fill < FILL_W'(LOG_DEPTH))) begin
            n_fill = r_fill + FILL_W'(1);
        end
        if (i_ctrl.pop && (r_fill != '0)) begin
            n_head = (r_head == IDX_W'(LOG_DEPTH-1)) ? '0 : r_head + IDX_W'(1);
            n_fill = r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    // Memory: one write port at the tail, registered read at the head.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && (r_fill < FILL_W'(LOG_DEPTH))) begin
            r_mem[tail] <= i_wdata;
        end
        r_rd_data <= r_mem[r_head];
    end

    assign o_head_data = r_rd_data;
    assign o_fill      = r_fill;

endmodule
